@@ rtl/core/i2rs_pkg.sv @@
// Shared types and constants for the integer to radix symbols block.
// No dependencies; used by i2rs_ctrl, i2rs_dp and integer_to_radix_symbols.
package i2rs_pkg;

  localparam int NUM_SYMS   = 16;
  localparam int SYM_W      = 8;
  localparam int DIGIT_W    = 4;
  localparam int RADIX_W    = 5;
  localparam int NUM_W      = 32;
  localparam int MAX_DIGITS = 32;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int BITS_PER_STEP = 8;

  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_NUL   = 8'h00;
  localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

  localparam logic STATUS_OK           = 1'b0;
  localparam logic STATUS_BAD_ALPHABET = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX        = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_DIGIT,
    ST_ERROR
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_sign;
    logic emit_digit;
    logic emit_error;
  } i2rs_cmd_t;

  typedef struct packed {
    logic alpha_ok;
    logic neg;
    logic div_done;
    logic last_digit;
    logic out_free;
  } i2rs_sts_t;

endpackage

@@ rtl/core/integer_to_radix_symbols.sv @@
// Top level of the integer to radix symbols block.
// Depends on i2rs_pkg, i2rs_ctrl and i2rs_dp.
//
//   Channel  Ports                                         Word
//   in       in_valid / in_ready, in_number                one signed 32-bit number
//   out      out_valid / out_ready, out_symbol,            one character of the text
//            out_status, out_is_last
//   cfg      cfg_we, cfg_index, cfg_wdata                  one register write, no wait
//
// A number is checked, divided digit by digit and then sent as one character per
// digit, led by a minus sign when it is negative. The divider retires eight quotient
// bits per cycle; the single output register then sends one character per cycle
// while the receiver is ready.
// Reset is synchronous and active low; it clears the configuration registers to zero,
// which is an invalid alphabet until configured. A stalled output holds the state
// machine in its emit state; the next number is taken as soon as the last character
// is registered.
module integer_to_radix_symbols #(
  parameter int MAX_RADIX = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [i2rs_pkg::NUM_W-1:0]     in_number,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [i2rs_pkg::SYM_W-1:0]            out_symbol,
  output logic                                  out_status,
  output logic                                  out_is_last,
  input  logic                                  cfg_we,
  input  logic [i2rs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [i2rs_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  // Commands flow from the controller into the datapath, status flows back.
  i2rs_pkg::i2rs_cmd_t cmd;
  i2rs_pkg::i2rs_sts_t sts;

  // The controller sequences accept, alphabet check, division and emission.
  i2rs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the configuration, the divider, the digit stack (digits are
  // produced least significant first and read back in reverse) and the output register.
  i2rs_dp #(
    .MAX_RADIX (MAX_RADIX)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_number   (in_number),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_symbol  (out_symbol),
    .out_status  (out_status),
    .out_is_last (out_is_last),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

@@ rtl/core/i2rs_ctrl.sv @@
// Controller state machine for the integer to radix symbols block.
// Depends on i2rs_pkg; drives the datapath i2rs_dp through command and status structs.
module i2rs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2rs_pkg::i2rs_sts_t sts,
  output i2rs_pkg::i2rs_cmd_t cmd
);

  i2rs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i2rs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      i2rs_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = i2rs_pkg::ST_CHECK;
      end
      i2rs_pkg::ST_CHECK: begin
        state_nxt = sts.alpha_ok ? i2rs_pkg::ST_DIV : i2rs_pkg::ST_ERROR;
      end
      i2rs_pkg::ST_DIV: begin
        if (sts.div_done) state_nxt = sts.neg ? i2rs_pkg::ST_SIGN : i2rs_pkg::ST_DIGIT;
      end
      i2rs_pkg::ST_SIGN: begin
        if (sts.out_free) state_nxt = i2rs_pkg::ST_DIGIT;
      end
      i2rs_pkg::ST_DIGIT: begin
        if (sts.out_free && sts.last_digit) state_nxt = i2rs_pkg::ST_IDLE;
      end
      i2rs_pkg::ST_ERROR: begin
        if (sts.out_free) state_nxt = i2rs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = i2rs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    case (state_r)
      i2rs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      i2rs_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      i2rs_pkg::ST_SIGN: begin
        cmd.emit_sign = sts.out_free;
      end
      i2rs_pkg::ST_DIGIT: begin
        cmd.emit_digit = sts.out_free;
      end
      i2rs_pkg::ST_ERROR: begin
        cmd.emit_error = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/i2rs_dp.sv @@
// Datapath for the integer to radix symbols block: configuration registers,
// alphabet check, radix divider, digit stack and output register. Depends on i2rs_pkg.
module i2rs_dp #(
  parameter int MAX_RADIX = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [i2rs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [i2rs_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic signed [i2rs_pkg::NUM_W-1:0]     in_number,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [i2rs_pkg::SYM_W-1:0]            out_symbol,
  output logic                                  out_status,
  output logic                                  out_is_last,
  input  i2rs_pkg::i2rs_cmd_t                   cmd,
  output i2rs_pkg::i2rs_sts_t                   sts
);

  localparam int SYM_W   = i2rs_pkg::SYM_W;
  localparam int DIGIT_W = i2rs_pkg::DIGIT_W;
  localparam int NUM_W   = i2rs_pkg::NUM_W;
  localparam int CNT_W   = i2rs_pkg::CNT_W;
  localparam int BPS     = i2rs_pkg::BITS_PER_STEP;
  localparam int IDX_W   = $clog2(i2rs_pkg::MAX_DIGITS);
  localparam int STEP_W  = $clog2(NUM_W / BPS);

  // Configuration registers.
  logic [i2rs_pkg::CFG_DATA_W-1:0] sym_lo_r, sym_hi_r;
  logic [i2rs_pkg::RADIX_W-1:0]    radix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_lo_r <= '0;
      sym_hi_r <= '0;
      radix_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        i2rs_pkg::CFG_SYMBOLS_LOW:  sym_lo_r <= cfg_wdata;
        i2rs_pkg::CFG_SYMBOLS_HIGH: sym_hi_r <= cfg_wdata;
        i2rs_pkg::CFG_RADIX:        radix_r  <= cfg_wdata[i2rs_pkg::RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Alphabet view and validity check: radix range, forbidden symbols and all used symbol pairs.
  logic [SYM_W-1:0]             sym_c [i2rs_pkg::NUM_SYMS];
  logic [i2rs_pkg::NUM_SYMS-1:0] used_c;
  logic                          alpha_ok_c;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sym_c[i]     = sym_lo_r[SYM_W*i +: SYM_W];
      sym_c[i + 8] = sym_hi_r[SYM_W*i +: SYM_W];
    end
    for (int i = 0; i < i2rs_pkg::NUM_SYMS; i++) begin
      used_c[i] = (i2rs_pkg::RADIX_W'(i) < radix_r);
    end
    alpha_ok_c = (radix_r >= i2rs_pkg::MIN_RADIX) &&
                 (radix_r <= i2rs_pkg::RADIX_W'(MAX_RADIX));
    for (int i = 0; i < i2rs_pkg::NUM_SYMS; i++) begin
      if (used_c[i] && (sym_c[i] == i2rs_pkg::SYM_NUL || sym_c[i] == i2rs_pkg::SYM_PLUS ||
                        sym_c[i] == i2rs_pkg::SYM_MINUS)) begin
        alpha_ok_c = 1'b0;
      end
      for (int j = i + 1; j < i2rs_pkg::NUM_SYMS; j++) begin
        if (used_c[i] && used_c[j] && sym_c[i] == sym_c[j]) alpha_ok_c = 1'b0;
      end
    end
  end

  // Divider: restoring long division, BPS quotient bits per cycle.
  logic [NUM_W-1:0]   dv_r;
  logic [DIGIT_W-1:0] rem_r;
  logic [STEP_W-1:0]  step_r;
  logic [CNT_W-1:0]   nd_r;
  logic               neg_r;
  logic [DIGIT_W-1:0] dig_r [i2rs_pkg::MAX_DIGITS];

  logic [NUM_W-1:0]   raw_c, mag_c;
  logic [DIGIT_W:0]   trial_c;
  logic [DIGIT_W-1:0] rem_nxt;
  logic [BPS-1:0]     qbits_c;
  logic [NUM_W-1:0]   quo_nxt;
  logic               step_last_c;

  assign raw_c = unsigned'(in_number);
  assign mag_c = raw_c[NUM_W-1] ? (NUM_W'(0) - raw_c) : raw_c;

  always_comb begin
    rem_nxt = rem_r;
    qbits_c = '0;
    trial_c = '0;
    for (int k = 0; k < BPS; k++) begin
      trial_c = {rem_nxt, dv_r[NUM_W-1-k]};
      if (trial_c >= radix_r) begin
        rem_nxt            = DIGIT_W'(trial_c - radix_r);
        qbits_c[BPS-1-k]   = 1'b1;
      end else begin
        rem_nxt = trial_c[DIGIT_W-1:0];
      end
    end
    quo_nxt = {dv_r[NUM_W-BPS-1:0], qbits_c};
  end

  assign step_last_c = (step_r == STEP_W'((NUM_W / BPS) - 1));

  // Digit stack read: top entry sits at nd_r - 1.
  logic [CNT_W-1:0]   rd_ptr_c;
  logic [DIGIT_W-1:0] rd_digit_c;

  assign rd_ptr_c   = nd_r - CNT_W'(1);
  assign rd_digit_c = dig_r[rd_ptr_c[IDX_W-1:0]];

  // Control registers of the datapath.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nd_r        <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        nd_r   <= '0;
        step_r <= '0;
      end else if (cmd.div_step) begin
        step_r <= step_r + STEP_W'(1);
        if (step_last_c) nd_r <= nd_r + CNT_W'(1);
      end else if (cmd.emit_digit) begin
        nd_r <= rd_ptr_c;
      end
      if (cmd.emit_sign || cmd.emit_digit || cmd.emit_error) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  logic [SYM_W-1:0] out_symbol_r;
  logic             out_status_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dv_r  <= mag_c;
      rem_r <= '0;
      neg_r <= raw_c[NUM_W-1];
    end else if (cmd.div_step) begin
      dv_r <= quo_nxt;
      if (step_last_c) begin
        dig_r[nd_r[IDX_W-1:0]] <= rem_nxt;
        rem_r                  <= '0;
      end else begin
        rem_r <= rem_nxt;
      end
    end
    if (cmd.emit_sign) begin
      out_symbol_r <= i2rs_pkg::SYM_MINUS;
      out_status_r <= i2rs_pkg::STATUS_OK;
      out_last_r   <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_symbol_r <= sym_c[rd_digit_c];
      out_status_r <= i2rs_pkg::STATUS_OK;
      out_last_r   <= (nd_r == CNT_W'(1));
    end else if (cmd.emit_error) begin
      out_symbol_r <= i2rs_pkg::SYM_NUL;
      out_status_r <= i2rs_pkg::STATUS_BAD_ALPHABET;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_symbol  = out_symbol_r;
  assign out_status  = out_status_r;
  assign out_is_last = out_last_r;

  assign sts.alpha_ok   = alpha_ok_c;
  assign sts.neg        = neg_r;
  assign sts.div_done   = step_last_c &&
                          (quo_nxt == '0 || nd_r == CNT_W'(i2rs_pkg::MAX_DIGITS - 1));
  assign sts.last_digit = (nd_r == CNT_W'(1));
  assign sts.out_free   = !out_valid_r || out_ready;

  // The stack is never popped when empty.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_digit |-> nd_r != '0)
    else $error("digit emitted from an empty stack");

  // The digit count never exceeds one digit per magnitude bit.
  a_nd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nd_r <= CNT_W'(i2rs_pkg::MAX_DIGITS))
    else $error("digit count beyond its bound");

  // An error word carries a zero symbol and closes its number.
  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> out_last_r && out_symbol_r == i2rs_pkg::SYM_NUL)
    else $error("malformed error word");

  // A new number starts the divider from a clean state.
  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> step_r == '0 && nd_r == '0 && rem_r == '0)
    else $error("divider not cleared on a new number");

endmodule

@@ test/tb_integer_to_radix_symbols.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for integer_to_radix_symbols: numbers in, text words out.
// Depends on i2rs_pkg and the integer_to_radix_symbols RTL; needs nothing else.
module tb_integer_to_radix_symbols;

  localparam int MAX_RADIX    = 16;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 39;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 1000000;

  localparam int SYM_W      = i2rs_pkg::SYM_W;
  localparam int NUM_W      = i2rs_pkg::NUM_W;
  localparam int DIGIT_W    = i2rs_pkg::DIGIT_W;
  localparam int RADIX_W    = i2rs_pkg::RADIX_W;
  localparam int NUM_SYMS   = i2rs_pkg::NUM_SYMS;
  localparam int CFG_IDX_W  = i2rs_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = i2rs_pkg::CFG_DATA_W;

  // Index 3 decodes to no register; a write there must leave the alphabet alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Ways a random alphabet is broken on purpose.
  typedef enum int {
    FLAW_NONE,
    FLAW_RADIX_LOW,
    FLAW_RADIX_HIGH,
    FLAW_REPEAT,
    FLAW_PLUS,
    FLAW_MINUS,
    FLAW_NUL
  } flaw_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             status;
    logic             is_last;
  } text_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [NUM_W-1:0]      in_number = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SYM_W-1:0]      out_symbol;
  logic                  out_status;
  logic                  out_is_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Our own copy of the configuration registers, reset values included.
  logic [CFG_DATA_W-1:0] symbols_low_cfg = '0;
  logic [CFG_DATA_W-1:0] symbols_high_cfg = '0;
  logic [RADIX_W-1:0]    radix_cfg = '0;

  logic [NUM_W-1:0] pending_numbers [$];
  text_word_t       expected_words [$];

  int  errors = 0;
  int  numbers_sent = 0;
  int  words_checked = 0;
  int  alphabets_loaded = 0;
  int  cycle_count = 0;
  logic quiet = 1'b0;
  int  send_idle = 0;
  int  ready_idle = 0;
  int  hold_left = 0;
  int  hold_ticket = 0;
  int  hold_seen = 0;

  integer_to_radix_symbols #(
    .MAX_RADIX(MAX_RADIX)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_number  (in_number),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_symbol (out_symbol),
    .out_status (out_status),
    .out_is_last(out_is_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Symbol i of the configured alphabet; symbols 8 to 15 live in the high register.
  function automatic logic [SYM_W-1:0] symbol_at(input int unsigned i);
    logic [2*CFG_DATA_W-1:0] all_syms;
    all_syms = {symbols_high_cfg, symbols_low_cfg};
    return all_syms[SYM_W*i +: SYM_W];
  endfunction

  // The alphabet is usable only if the radix is in range and the used symbols are
  // distinct, nonzero and neither sign character.
  function automatic bit alphabet_valid();
    int unsigned n;
    logic [SYM_W-1:0] c;
    n = 32'(radix_cfg);
    if (n < 32'(i2rs_pkg::MIN_RADIX) || n > MAX_RADIX) return 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      c = symbol_at(i);
      if (c == i2rs_pkg::SYM_NUL || c == i2rs_pkg::SYM_PLUS || c == i2rs_pkg::SYM_MINUS)
        return 1'b0;
      for (int unsigned j = i + 1; j < n; j++) begin
        if (symbol_at(j) == c) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void queue_word(input logic [SYM_W-1:0] symbol, input logic status,
                                     input logic is_last);
    text_word_t w;
    w.symbol  = symbol;
    w.status  = status;
    w.is_last = is_last;
    expected_words.push_back(w);
  endfunction

  // Works out the text of one number under the current alphabet and queues its words.
  function automatic void predict_text(input logic [NUM_W-1:0] value);
    logic [NUM_W-1:0]   mag;
    logic [NUM_W-1:0]   base;
    logic [DIGIT_W-1:0] digits [$];
    logic [DIGIT_W-1:0] d;
    if (!alphabet_valid()) begin
      queue_word(i2rs_pkg::SYM_NUL, i2rs_pkg::STATUS_BAD_ALPHABET, 1'b1);
      return;
    end
    base = NUM_W'(radix_cfg);
    // The magnitude is taken as unsigned, so the most negative number needs no special path.
    mag = value[NUM_W-1] ? -value : value;
    do begin
      digits.push_front(DIGIT_W'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    if (value[NUM_W-1]) queue_word(i2rs_pkg::SYM_MINUS, i2rs_pkg::STATUS_OK, 1'b0);
    while (digits.size() != 0) begin
      d = digits.pop_front();
      queue_word(symbol_at(32'(d)), i2rs_pkg::STATUS_OK, digits.size() == 0);
    end
  endfunction

  // Random alphabet: the first n symbols distinct and legal, the unused ones anything at
  // all, then one flaw planted among the used symbols if asked for.
  function automatic logic [2*CFG_DATA_W-1:0] build_alphabet(input int unsigned n,
                                                             input flaw_t flaw);
    logic [2*CFG_DATA_W-1:0] syms;
    bit taken [256];
    logic [SYM_W-1:0] c;
    int unsigned i;
    int unsigned j;
    for (i = 0; i < NUM_SYMS; i++) syms[SYM_W*i +: SYM_W] = SYM_W'($urandom_range(0, 255));
    for (i = 0; i < n; i++) begin
      do begin
        c = SYM_W'($urandom_range(1, 255));
      end while (c == i2rs_pkg::SYM_PLUS || c == i2rs_pkg::SYM_MINUS || taken[c]);
      taken[c] = 1'b1;
      syms[SYM_W*i +: SYM_W] = c;
    end
    i = $urandom_range(0, n - 1);
    case (flaw)
      FLAW_REPEAT: begin
        j = $urandom_range(0, n - 2);
        if (j >= i) j++;
        syms[SYM_W*j +: SYM_W] = syms[SYM_W*i +: SYM_W];
      end
      FLAW_PLUS:  syms[SYM_W*i +: SYM_W] = i2rs_pkg::SYM_PLUS;
      FLAW_MINUS: syms[SYM_W*i +: SYM_W] = i2rs_pkg::SYM_MINUS;
      FLAW_NUL:   syms[SYM_W*i +: SYM_W] = i2rs_pkg::SYM_NUL;
      default: ;
    endcase
    return syms;
  endfunction

  // A mix of values near zero, the extremes, random magnitudes of random length and
  // plain random words, so every bit of the number sees both values.
  function automatic logic [NUM_W-1:0] pick_number();
    logic [NUM_W-1:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom_range(0, 40) - 20;
      1: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      2: begin
        v = $urandom() >> $urandom_range(1, 31);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Blocks until nothing is queued, offered or outstanding.
  task automatic wait_drained();
    while (pending_numbers.size() != 0 || in_valid || expected_words.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      i2rs_pkg::CFG_SYMBOLS_LOW:  symbols_low_cfg = data;
      i2rs_pkg::CFG_SYMBOLS_HIGH: symbols_high_cfg = data;
      i2rs_pkg::CFG_RADIX:        radix_cfg = data[RADIX_W-1:0];
      default: ;
    endcase
  endtask

  // Loads a whole alphabet once the block has gone idle; returns on a falling edge so
  // that numbers can be queued without racing the driver.
  task automatic write_alphabet(input logic [RADIX_W-1:0] r,
                                input logic [2*CFG_DATA_W-1:0] syms);
    wait_drained();
    repeat (4) @(negedge clk);
    write_reg(i2rs_pkg::CFG_SYMBOLS_LOW, syms[CFG_DATA_W-1:0]);
    write_reg(i2rs_pkg::CFG_SYMBOLS_HIGH, syms[2*CFG_DATA_W-1:CFG_DATA_W]);
    write_reg(i2rs_pkg::CFG_RADIX, CFG_DATA_W'(r));
    alphabets_loaded++;
    @(negedge clk);
  endtask

  // Input driver. A word is offered until taken; between words it may insert a random
  // idle burst. The prediction is made at the edge that accepts a word.
  always @(posedge clk) begin : drive_p
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_idle <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_text(in_number);
        numbers_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_idle != 0) begin
          send_idle <= send_idle - 1;
          in_valid  <= 1'b0;
        end else if (!quiet && pending_numbers.size() != 0 && $urandom_range(0, 4) == 0) begin
          send_idle <= $urandom_range(0, 2);
          in_valid  <= 1'b0;
        end else if (pending_numbers.size() != 0) begin
          in_valid  <= 1'b1;
          in_number <= pending_numbers.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output ready. Random short stalls, plus one long hold-off whenever the stimulus bumps
  // the hold ticket; the hold is counted here so it runs regardless of the sender.
  always @(posedge clk) begin : ready_p
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_idle <= 0;
      hold_left  <= 0;
      hold_seen  <= 0;
    end else if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (ready_idle != 0) begin
      ready_idle <= ready_idle - 1;
      out_ready  <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      ready_idle <= $urandom_range(0, 2);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Output monitor. Every accepted word is matched against the oldest prediction.
  always @(posedge clk) begin : check_p
    text_word_t want;
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, actual symbol %02h status %0b is_last %0b",
                 $time, out_symbol, out_status, out_is_last);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (out_symbol !== want.symbol) begin
          $display("%0t: symbol mismatch, expected %02h actual %02h",
                   $time, want.symbol, out_symbol);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status mismatch, expected %0b actual %0b",
                   $time, want.status, out_status);
          errors++;
        end
        if (out_is_last !== want.is_last) begin
          $display("%0t: is_last mismatch, expected %0b actual %0b",
                   $time, want.is_last, out_is_last);
          errors++;
        end
      end
    end
  end

  // Watchdog. The limit is several times the slowest legal run: every number in binary
  // with a sign, every word waiting out a stall, plus the long hold-off.
  always @(posedge clk) begin : watchdog_p
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d numbers queued and %0d words outstanding",
               $time, pending_numbers.size(), expected_words.size());
      $display("tb_integer_to_radix_symbols: done, errors");
      $finish;
    end
  end

  initial begin : stimulus_p
    logic [2*CFG_DATA_W-1:0] syms;
    logic [RADIX_W-1:0]      r;
    int unsigned             n;
    flaw_t                   flaw;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Straight out of reset the radix is zero, so a number must draw the error word.
    pending_numbers.push_back(32'd5);

    // A write to the unused index must not disturb anything.
    wait_drained();
    write_reg(CFG_SPARE, {$urandom(), $urandom()});
    @(negedge clk);
    pending_numbers.push_back(32'hFFFF_FFF6);

    // Decimal with the usual digit characters: zero, small values of both signs, a
    // carry into a new digit, and both ends of the range.
    for (int i = 0; i < 10; i++) syms[SYM_W*i +: SYM_W] = SYM_W'(8'h30 + i);
    write_alphabet(5'd10, syms);
    pending_numbers.push_back(32'd0);
    pending_numbers.push_back(32'd7);
    pending_numbers.push_back(32'hFFFF_FFFF);
    pending_numbers.push_back(32'd10);
    pending_numbers.push_back(32'h7FFF_FFFF);
    pending_numbers.push_back(32'h8000_0000);
    pending_numbers.push_back(32'd1000000000);

    // Binary is the longest text: 32 digits plus the sign for the most negative number.
    write_alphabet(5'd2, build_alphabet(2, FLAW_NONE));
    pending_numbers.push_back(32'd0);
    pending_numbers.push_back(32'hFFFF_FFFF);
    pending_numbers.push_back(32'h7FFF_FFFF);
    pending_numbers.push_back(32'h8000_0000);

    // Full sixteen-symbol alphabet with the smallest and largest legal symbol bytes.
    for (int i = 0; i < NUM_SYMS; i++)
      syms[SYM_W*i +: SYM_W] = (i == 0) ? 8'h01 : SYM_W'(8'hF0 + i);
    write_alphabet(5'd16, syms);
    pending_numbers.push_back(32'd0);
    pending_numbers.push_back(32'h8000_0000);
    pending_numbers.push_back(32'hFFFF_FFFF);

    // Broken alphabets: radix one, radix just above the maximum, the largest radix code,
    // and a repeated symbol, a plus, a minus and a zero byte among the used symbols.
    write_alphabet(5'd1, build_alphabet(NUM_SYMS, FLAW_NONE));
    pending_numbers.push_back(pick_number());
    write_alphabet(5'(MAX_RADIX + 1), build_alphabet(NUM_SYMS, FLAW_NONE));
    pending_numbers.push_back(pick_number());
    write_alphabet(5'd31, build_alphabet(NUM_SYMS, FLAW_NONE));
    pending_numbers.push_back(pick_number());
    for (int f = FLAW_REPEAT; f <= FLAW_NUL; f++) begin
      n = $urandom_range(2, MAX_RADIX);
      write_alphabet(5'(n), build_alphabet(n, flaw_t'(f)));
      pending_numbers.push_back(pick_number());
    end

    // Random phases, one alphabet each. The first two pin the radix extremes; every fifth
    // alphabet is broken in a random way. One phase starts under a long receiver hold-off
    // with its whole batch already queued, another pauses halfway until the block is empty,
    // and the last two run with no idling on either side.
    for (int p = 0; p < NUM_PHASES; p++) begin
      n = (p == 0) ? 2 : (p == 1) ? MAX_RADIX : $urandom_range(2, MAX_RADIX);
      r = 5'(n);
      flaw = FLAW_NONE;
      if (p % 5 == 4) flaw = flaw_t'($urandom_range(FLAW_RADIX_LOW, FLAW_NUL));
      if (flaw == FLAW_RADIX_LOW) r = 5'($urandom_range(0, 1));
      else if (flaw == FLAW_RADIX_HIGH) r = 5'($urandom_range(MAX_RADIX + 1, 31));
      write_alphabet(r, build_alphabet(n, flaw));
      if (p == NUM_PHASES - 2) quiet <= 1'b1;
      if (p == 3) hold_ticket <= hold_ticket + 1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 5 && k == PHASE_ITEMS / 2) wait_drained();
        pending_numbers.push_back(pick_number());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Converted %0d numbers into %0d checked words under %0d alphabets,",
             numbers_sent, words_checked, alphabets_loaded);
    $display("radix 2 to 16 and broken alphabets, with short stalls and one long hold-off.");
    if (errors == 0) begin
      $display("tb_integer_to_radix_symbols: done, clean");
    end else begin
      $display("tb_integer_to_radix_symbols: done, errors");
    end
    $finish;
  end

endmodule
